FILE: rtl/core/qpsc_pkg.sv
// Shared types and constants for the quadrature position and speed counter.
// Used by the front, queue, back and top-level files; no dependencies.
`default_nettype none
package qpsc_pkg;

	// Request type codes on the input channel.
	localparam logic [1:0] REQ_STEP  = 2'd0;
	localparam logic [1:0] REQ_INDEX = 2'd1;
	localparam logic [1:0] REQ_SPEED = 2'd2;

	// Direction codes, two-bit signed.
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_REV  = 2'b11;

	// Step per transition code, indexed by {old AB, new AB}.
	localparam logic [1:0] QUAD_STEP [0:15] = '{
		DIR_NONE, DIR_FWD,  DIR_REV,  DIR_NONE,
		DIR_REV,  DIR_NONE, DIR_NONE, DIR_FWD,
		DIR_FWD,  DIR_NONE, DIR_NONE, DIR_REV,
		DIR_NONE, DIR_REV,  DIR_FWD,  DIR_NONE
	};

	localparam int unsigned POS_W   = 32;
	localparam int unsigned ELAP_W  = 32;
	localparam int unsigned PPR_W   = 16;
	localparam int unsigned SCALE_W = 26;
	localparam int unsigned NUM_W   = 57;
	localparam int unsigned DEN_W   = ELAP_W + PPR_W;

	localparam logic [SCALE_W-1:0] RPM_SCALE = 26'd60000000;
	localparam logic [PPR_W-1:0]   PPR_RESET = 16'd1024;
	localparam int unsigned        QUEUE_DEPTH = 2;

	// Classified operation handed from the front to the back.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_FWD,
		OP_REV,
		OP_INDEX,
		OP_SPEED
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [ELAP_W-1:0]   elapsed;
	} op_t;

endpackage
`default_nettype wire

FILE: rtl/core/qpsc_front.sv
// Front end: accepts input items and classifies them into operations.
// Depends on qpsc_pkg; feeds qpsc_queue.
`default_nettype none
module qpsc_front (
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  req_type,
	input  wire logic [3:0]                  ab_code,
	input  wire logic [qpsc_pkg::ELAP_W-1:0] elapsed_us,
	input  wire logic                        q_full,
	output logic                             q_push,
	output qpsc_pkg::op_t                    q_op
);
	import qpsc_pkg::*;

	logic [1:0] step;

	assign step     = QUAD_STEP[ab_code];
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_op.elapsed = elapsed_us;
		unique case (req_type)
			REQ_STEP: begin
				if (step == DIR_FWD) begin
					q_op.kind = OP_FWD;
				end else if (step == DIR_REV) begin
					q_op.kind = OP_REV;
				end else begin
					q_op.kind = OP_NONE;
				end
			end
			REQ_INDEX: q_op.kind = OP_INDEX;
			REQ_SPEED: q_op.kind = OP_SPEED;
			default:   q_op.kind = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/core/qpsc_queue.sv
// Short register queue between the front and the back.
// Depends on qpsc_pkg for the operation type.
`default_nettype none
module qpsc_queue #(
	parameter int unsigned DEPTH = qpsc_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire qpsc_pkg::op_t push_op,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output qpsc_pkg::op_t      head_op
);
	import qpsc_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	op_t           entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_op   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/qpsc_back.sv
// Back end: holds position state, runs the speed divider, drives results.
// Depends on qpsc_pkg; takes operations from qpsc_queue.
`default_nettype none
module qpsc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  wire qpsc_pkg::op_t               q_op,
	output logic                             q_pop,
	input  wire logic                        cfg_we,
	input  wire logic [qpsc_pkg::PPR_W-1:0]  cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [qpsc_pkg::POS_W-1:0] position,
	output logic signed [qpsc_pkg::POS_W-1:0] revolutions,
	output logic signed [1:0]                direction,
	output logic signed [qpsc_pkg::POS_W-1:0] rpm,
	output logic                             rpm_valid
);
	import qpsc_pkg::*;

	localparam int unsigned QUOT_W = 32;
	localparam int unsigned CNT_W  = $clog2(QUOT_W);

	typedef enum logic [4:0] {
		BK_RUN = 5'b00001,
		BK_MUL = 5'b00010,
		BK_CHK = 5'b00100,
		BK_DIV = 5'b01000,
		BK_OUT = 5'b10000
	} bk_state_t;

	bk_state_t          state_q;
	logic [PPR_W-1:0]   ppr_q;
	logic [POS_W-1:0]   step_q;
	logic [POS_W-1:0]   rev_q;
	logic [1:0]         dir_q;
	logic [POS_W-1:0]   sampled_q;

	logic [POS_W-1:0]   mag_q;
	logic               neg_q;
	logic [ELAP_W-1:0]  elapsed_q;
	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [POS_W-1:0]   pos_out_q;
	logic [POS_W-1:0]   rev_out_q;
	logic [1:0]         dir_out_q;
	logic [POS_W-1:0]   rpm_out_q;
	logic               rpmv_out_q;

	logic               out_free;
	logic               out_load;
	logic [POS_W-1:0]   step_nxt;
	logic [POS_W-1:0]   rev_nxt;
	logic [1:0]         dir_nxt;
	logic               speed_ok;
	logic [POS_W-1:0]   moved;
	logic [SCALE_W+POS_W-1:0] num_prod;
	logic [DEN_W-1:0]   den_prod;
	logic [DEN_W:0]     rem_sh;
	logic [DEN_W:0]     rem_diff;
	logic               rem_ge;
	logic               quot_ovf;
	logic [POS_W-1:0]   rpm_final;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == BK_RUN) && q_valid && out_free;
	assign speed_ok = (q_op.elapsed != '0) && (ppr_q != '0);
	assign moved    = step_q - sampled_q;
	assign out_load = (q_pop && !(q_op.kind == OP_SPEED && speed_ok)) ||
		(state_q == BK_OUT && out_free);

	always_comb begin
		step_nxt = step_q;
		rev_nxt  = rev_q;
		dir_nxt  = dir_q;
		case (q_op.kind)
			OP_FWD: begin
				step_nxt = step_q + 1'b1;
				dir_nxt  = DIR_FWD;
			end
			OP_REV: begin
				step_nxt = step_q - 1'b1;
				dir_nxt  = DIR_REV;
			end
			OP_INDEX: begin
				if (dir_q == DIR_FWD) begin
					rev_nxt = rev_q + 1'b1;
				end else if (dir_q == DIR_REV) begin
					rev_nxt = rev_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign num_prod  = {{SCALE_W{1'b0}}, mag_q} * {{POS_W{1'b0}}, RPM_SCALE};
	assign den_prod  = {{PPR_W{1'b0}}, elapsed_q} * {{ELAP_W{1'b0}}, ppr_q};
	assign rem_sh    = {rem_q, quot_q[QUOT_W-1]};
	assign rem_diff  = rem_sh - {1'b0, den_q};
	assign rem_ge    = (rem_sh >= {1'b0, den_q});
	assign quot_ovf  = ({{(DEN_W-(NUM_W-QUOT_W+1)){1'b0}}, num_q[NUM_W-1:QUOT_W-1]} >= den_q);
	assign rpm_final = neg_q ? (32'd0 - quot_q) : quot_q;

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_RUN: begin
				mag_q     <= moved[POS_W-1] ? (32'd0 - moved) : moved;
				neg_q     <= moved[POS_W-1];
				elapsed_q <= q_op.elapsed;
			end
			BK_MUL: begin
				num_q <= num_prod[NUM_W-1:0];
				den_q <= den_prod;
			end
			BK_CHK: begin
				rem_q  <= {{(DEN_W-(NUM_W-QUOT_W)){1'b0}}, num_q[NUM_W-1:QUOT_W]};
				// Quotient would not fit: clamp; negating the negative limit keeps it.
				quot_q <= quot_ovf ? (neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF)
					: num_q[QUOT_W-1:0];
				cnt_q  <= '0;
			end
			BK_DIV: begin
				rem_q  <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
				quot_q <= {quot_q[QUOT_W-2:0], rem_ge};
				cnt_q  <= cnt_q + 1'b1;
			end
			BK_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			ppr_q       <= PPR_RESET;
			step_q      <= '0;
			rev_q       <= '0;
			dir_q       <= DIR_NONE;
			sampled_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ppr_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_RUN: begin
					if (q_pop) begin
						step_q <= step_nxt;
						rev_q  <= rev_nxt;
						dir_q  <= dir_nxt;
						if (q_op.kind == OP_SPEED && speed_ok) begin
							sampled_q <= step_q;
							state_q   <= BK_MUL;
						end
					end
				end
				BK_MUL: state_q <= BK_CHK;
				BK_CHK: begin
					if (quot_ovf) begin
						state_q <= BK_OUT;
					end else begin
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					if (cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= BK_OUT;
					end
				end
				BK_OUT: begin
					if (out_free) begin
						state_q <= BK_RUN;
					end
				end
				default: state_q <= BK_RUN;
			endcase
		end
	end

	// Result payload, loaded together with the valid flag.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pos_out_q  <= step_nxt;
			rev_out_q  <= rev_nxt;
			dir_out_q  <= dir_nxt;
			rpm_out_q  <= '0;
			rpmv_out_q <= 1'b0;
		end else if (state_q == BK_OUT && out_free) begin
			pos_out_q  <= step_q;
			rev_out_q  <= rev_q;
			dir_out_q  <= dir_q;
			rpm_out_q  <= rpm_final;
			rpmv_out_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = pos_out_q;
	assign revolutions = rev_out_q;
	assign direction   = dir_out_q;
	assign rpm         = rpm_out_q;
	assign rpm_valid   = rpmv_out_q;

endmodule
`default_nettype wire

FILE: rtl/core/quadrature_position_speed_counter_top.sv
// Top level of the quadrature position and speed counter.
// Depends on qpsc_pkg, qpsc_front, qpsc_queue and qpsc_back.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------------------------
//   input     in_valid / in_stall  req_type, ab_code, elapsed_us
//   result    out_valid / out_stall position, revolutions, direction, rpm, rpm_valid
//   config    cfg_we               cfg_wdata (pulses per revolution)
//
// Transitions, index pulses and ignored requests are handled in the back end's run
// state alone, so a steady stream of them runs at one item per cycle while the result
// is not stalled, registered first in the queue and then in the result register.
// A speed request with a usable divisor occupies the back end from the accepting
// state that takes the magnitude through a multiplier state, an overflow check, the
// 32 steps of a restoring divider (skipped when saturated) and a result-load state.
// Reset is asynchronous and clears the counts, direction, sample and queue, and
// loads 1024 pulses per revolution. The input stalls only when the queue is full;
// a stalled result holds the back end but the front keeps filling the queue.
`default_nettype none
module quadrature_position_speed_counter_top #(
	parameter int unsigned QUEUE_DEPTH = qpsc_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    req_type,
	input  wire logic [3:0]                    ab_code,
	input  wire logic [qpsc_pkg::ELAP_W-1:0]   elapsed_us,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [qpsc_pkg::POS_W-1:0]  position,
	output logic signed [qpsc_pkg::POS_W-1:0]  revolutions,
	output logic signed [1:0]                  direction,
	output logic signed [qpsc_pkg::POS_W-1:0]  rpm,
	output logic                               rpm_valid,
	input  wire logic                          cfg_we,
	input  wire logic [qpsc_pkg::PPR_W-1:0]    cfg_wdata
);
	import qpsc_pkg::*;

	// Front-to-queue and queue-to-back connections.
	op_t  push_op;
	op_t  head_op;
	logic push;
	logic full;
	logic pop;
	logic not_empty;

	// The front only classifies; it never waits on the back except through a full queue.
	qpsc_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.ab_code    (ab_code),
		.elapsed_us (elapsed_us),
		.q_full     (full),
		.q_push     (push),
		.q_op       (push_op)
	);

	qpsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head_op   (head_op)
	);

	// The back owns all counter state, the divisor register and the result register.
	qpsc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (not_empty),
		.q_op        (head_op),
		.q_pop       (pop),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.revolutions (revolutions),
		.direction   (direction),
		.rpm         (rpm),
		.rpm_valid   (rpm_valid)
	);

endmodule
`default_nettype wire

FILE: dv/tb_quadrature_position_speed_counter_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the quadrature position and speed counter top level.
// Depends on qpsc_pkg and quadrature_position_speed_counter_top; needs nothing else.
module tb_quadrature_position_speed_counter_top;
	import qpsc_pkg::*;

	// The one request code that the package leaves unnamed; the block ignores it.
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam logic [63:0] SPEED_SCALE = 64'd60000000;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 60;

	// One item on the input channel.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  code;
		logic [31:0] elapsed;
	} encoder_event_t;

	// One item on the result channel.
	typedef struct packed {
		logic [31:0] position;
		logic [31:0] revolutions;
		logic [1:0]  direction;
		logic [31:0] rpm;
		logic        rpm_valid;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = REQ_STEP;
	logic [3:0] ab_code = 4'd0;
	logic [ELAP_W-1:0] elapsed_us = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] position;
	logic signed [POS_W-1:0] revolutions;
	logic signed [1:0] direction;
	logic signed [POS_W-1:0] rpm;
	logic rpm_valid;
	logic cfg_we = 1'b0;
	logic [PPR_W-1:0] cfg_wdata = '0;

	// Items waiting to be offered, and the readings still owed by the block.
	encoder_event_t encoder_events[$];
	reading_t due_readings[$];

	// Shadow of the counter state, advanced once per accepted item.
	logic [31:0] cnt_position = '0;
	logic [31:0] cnt_revs = '0;
	logic [1:0]  cnt_dir = DIR_NONE;
	logic [31:0] cnt_sampled = '0;
	logic [15:0] cnt_ppr = PPR_RESET;

	int issued_count = 0;
	int readings_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	logic in_taken = 1'b0;

	// Sender burst and gap counters, receiver stall counters.
	int burst_left = 1;
	int gap_left = 0;
	int run_left = 0;
	int stall_left = 0;

	// Current A/B level of the imaginary encoder that the stimulus follows.
	logic [1:0] enc_ab = 2'b00;

	quadrature_position_speed_counter_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.ab_code     (ab_code),
		.elapsed_us  (elapsed_us),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.revolutions (revolutions),
		.direction   (direction),
		.rpm         (rpm),
		.rpm_valid   (rpm_valid),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Position of an A/B level along the Gray sequence 00, 01, 11, 10.
	function automatic logic [1:0] gray_rank(input logic [1:0] ab);
		return {ab[1], ab[1] ^ ab[0]};
	endfunction

	// Works out the reading that one item yields and moves the shadow state on.
	function automatic reading_t advance_counter(input logic [1:0] kind,
			input logic [3:0] code, input logic [31:0] elapsed);
		reading_t r;
		logic [1:0] rank_step;
		logic [31:0] moved;
		logic [31:0] moved_abs;
		logic [63:0] den;
		logic [63:0] quot;
		r.rpm = '0;
		r.rpm_valid = 1'b0;
		case (kind)
			REQ_STEP: begin
				// One place along the Gray sequence is a step; two places or none is no step.
				rank_step = gray_rank(code[1:0]) - gray_rank(code[3:2]);
				if (rank_step == 2'd1) begin
					cnt_position = cnt_position + 32'd1;
					cnt_dir = DIR_FWD;
				end else if (rank_step == 2'd3) begin
					cnt_position = cnt_position - 32'd1;
					cnt_dir = DIR_REV;
				end
			end
			REQ_INDEX: begin
				if (cnt_dir == DIR_FWD)
					cnt_revs = cnt_revs + 32'd1;
				else if (cnt_dir == DIR_REV)
					cnt_revs = cnt_revs - 32'd1;
			end
			REQ_SPEED: begin
				if (elapsed != 32'd0 && cnt_ppr != 16'd0) begin
					moved = cnt_position - cnt_sampled;
					moved_abs = moved[31] ? 32'd0 - moved : moved;
					den = {32'd0, elapsed} * {48'd0, cnt_ppr};
					quot = ({32'd0, moved_abs} * SPEED_SCALE) / den;
					if (moved[31])
						r.rpm = (quot >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - quot[31:0];
					else
						r.rpm = (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
					r.rpm_valid = 1'b1;
					cnt_sampled = cnt_position;
				end
			end
			default: begin
			end
		endcase
		r.position = cnt_position;
		r.revolutions = cnt_revs;
		r.direction = cnt_dir;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Results are checked before the new item is predicted: an item accepted at
	// this edge can never have produced the result taken at the same edge.
	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("tb_quadrature_position_speed_counter_top: done, errors");
				$finish;
			end
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				readings_seen++;
				if (due_readings.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: reading with nothing outstanding", $realtime);
				end else begin
					want = due_readings.pop_front();
					report_field("position", want.position, position);
					report_field("revolutions", want.revolutions, revolutions);
					report_field("direction", {30'd0, want.direction}, {30'd0, direction});
					report_field("rpm", want.rpm, rpm);
					report_field("rpm_valid", {31'd0, want.rpm_valid}, {31'd0, rpm_valid});
				end
			end
			if (in_valid && !in_stall)
				due_readings.push_back(advance_counter(req_type, ab_code, elapsed_us));
		end
	end

	// Sender: offers items in bursts of random length separated by random gaps.
	// A held item does not change until it has been taken.
	always @(negedge clk) begin
		encoder_event_t ev;
		if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (encoder_events.size() > 0) begin
				ev = encoder_events.pop_front();
				req_type <= ev.kind;
				ab_code <= ev.code;
				elapsed_us <= ev.elapsed;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// Some bursts are followed by no gap at all, giving long unbroken runs.
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a short stall, then a free run of random length, sometimes long.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (run_left > 0) begin
			out_stall <= 1'b0;
			run_left <= run_left - 1;
		end else begin
			out_stall <= 1'b0;
			run_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 12);
			stall_left <= $urandom_range(1, 10);
		end
	end

	task automatic add_event(input logic [1:0] kind, input logic [3:0] code,
			input logic [31:0] elapsed);
		encoder_event_t ev;
		ev.kind = kind;
		ev.code = code;
		ev.elapsed = elapsed;
		encoder_events.push_back(ev);
		issued_count++;
	endtask

	// Walks the encoder a number of clean quadrature steps in one direction.
	task automatic walk(input int steps, input bit forward);
		logic [1:0] nab;
		for (int i = 0; i < steps; i++) begin
			case (enc_ab)
				2'b00: nab = forward ? 2'b01 : 2'b10;
				2'b01: nab = forward ? 2'b11 : 2'b00;
				2'b11: nab = forward ? 2'b10 : 2'b01;
				default: nab = forward ? 2'b00 : 2'b11;
			endcase
			add_event(REQ_STEP, {enc_ab, nab}, $urandom);
			enc_ab = nab;
		end
	endtask

	// Elapsed times from the very short to the full width, with zero now and then.
	function automatic logic [31:0] pick_elapsed();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1, 2: return $urandom_range(1, 50);
			3: return $urandom_range(1, 5000);
			4: return $urandom >> $urandom_range(0, 31);
			5: return $urandom;
			6: return 32'hFFFF_FFFF;
			default: return 32'd1;
		endcase
	endfunction

	// Mostly clean encoder motion with a drifting bias, mixed with index pulses,
	// speed requests, glitched codes and the ignored request type.
	task automatic gen_mix(input int count);
		int made;
		int bias;
		int pick;
		logic [3:0] code;
		made = 0;
		bias = 5;
		while (made < count) begin
			if (made % 50 == 0)
				bias = $urandom_range(0, 10);
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				walk(1, $urandom_range(0, 9) < bias);
				made++;
			end else if (pick < 70) begin
				code = 4'($urandom_range(0, 15));
				add_event(REQ_STEP, code, $urandom);
				enc_ab = code[1:0];
				made++;
			end else if (pick < 80) begin
				add_event(REQ_INDEX, 4'($urandom_range(0, 15)), $urandom);
				made++;
			end else if (pick < 93) begin
				add_event(REQ_SPEED, 4'($urandom_range(0, 15)), pick_elapsed());
				made++;
			end else begin
				// Ignored by the block, so not counted towards the requested count.
				add_event(REQ_IGNORED, 4'($urandom_range(0, 15)), $urandom);
			end
		end
	endtask

	// Waits until every item has been offered and answered, then lets the block
	// sit idle for a while before anything else happens.
	task automatic wait_idle();
		while (encoder_events.size() != 0 || in_valid || readings_seen != issued_count)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Written only while the block is idle, so the shadow copy can change at once.
	task automatic write_ppr(input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cnt_ppr = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed opening at the reset divisor of 1024 pulses per revolution:
		// an index pulse before any direction, zero elapsed time, the ignored
		// request type, a speed with nothing moved, then every transition code.
		add_event(REQ_INDEX, 4'h0, 32'd0);
		add_event(REQ_SPEED, 4'h0, 32'd0);
		add_event(REQ_IGNORED, 4'hF, 32'hFFFF_FFFF);
		add_event(REQ_SPEED, 4'hF, 32'd1);
		for (int c = 0; c < 16; c++)
			add_event(REQ_STEP, c[3:0], 32'd0);
		add_event(REQ_INDEX, 4'hF, 32'd0);
		add_event(REQ_STEP, 4'h2, 32'd0);
		add_event(REQ_INDEX, 4'h0, 32'd0);
		add_event(REQ_SPEED, 4'h0, 32'hFFFF_FFFF);
		enc_ab = 2'b10;
		wait_idle();

		// Smallest divisor: a fast forward run saturates high, a longer reverse
		// run saturates low.
		write_ppr(16'd1);
		walk(40, 1'b1);
		add_event(REQ_SPEED, 4'h0, 32'd1);
		walk(80, 1'b0);
		add_event(REQ_SPEED, 4'h0, 32'd1);
		add_event(REQ_INDEX, 4'h0, 32'd0);
		gen_mix(150);
		wait_idle();

		write_ppr(16'hFFFF);
		gen_mix(350);
		wait_idle();

		// A zero divisor turns every speed request into a no-result one.
		write_ppr(16'd0);
		gen_mix(60);
		wait_idle();

		write_ppr(16'($urandom_range(1, 64)));
		gen_mix(250);
		wait_idle();

		write_ppr(16'($urandom_range(1, 65535)));
		gen_mix(300);
		wait_idle();

		if (mismatch_count == 0 && due_readings.size() == 0)
			$display("tb_quadrature_position_speed_counter_top: done, clean");
		else
			$display("tb_quadrature_position_speed_counter_top: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/qpsc_pkg.sv
rtl/core/qpsc_front.sv
rtl/core/qpsc_queue.sv
rtl/core/qpsc_back.sv
rtl/core/quadrature_position_speed_counter_top.sv
dv/tb_quadrature_position_speed_counter_top.sv
